// ===== hdl/ttb_pkg.sv =====
// ttb_pkg: shared constants, types and the sine lookup for the twirl texture blender
// no dependencies; imported by every module of the block

package ttb_pkg;

    localparam int TEXTURE_DEPTH = 131072;
    localparam int TEX_AW        = $clog2(TEXTURE_DEPTH);
    localparam int TEXEL_W       = 8;
    localparam int MAP_W         = 16;
    localparam int TADDR_W       = 17;
    localparam int FRAME_W       = 16;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    // register index taken from paddr[2]
    localparam logic REG_FRAME_COUNT = 1'b0;

    // item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_DRAW  = 1'b1;

    typedef logic [TEX_AW-1:0]  t_tex_addr;
    typedef logic [TEXEL_W-1:0] t_texel;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_store_ctrl;

    // first quadrant of the shifted sine, entries 0..64
    localparam logic [6:0] QUARTER_WAVE [65] = '{
        7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd15,  7'd18,  7'd21,
        7'd24,  7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,
        7'd48,  7'd51,  7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,
        7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,  7'd85,  7'd88,
        7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
        7'd106, 7'd108, 7'd109, 7'd111, 7'd112, 7'd114, 7'd115, 7'd117,
        7'd118, 7'd119, 7'd120, 7'd121, 7'd122, 7'd123, 7'd124, 7'd124,
        7'd125, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127,
        7'd127
    };

    // 256-entry signed sine, range -128..127
    function automatic logic signed [7:0] sine_lookup(input logic [7:0] idx);
        logic [7:0] m;
        logic [6:0] q;
        logic [6:0] mag;
        begin
            m   = (idx <= 8'd128) ? idx : 8'(idx - 8'd128);
            q   = (m <= 8'd64) ? m[6:0] : 7'(8'd128 - m);
            mag = QUARTER_WAVE[q];
            // second half is -(mag + 1), which is the bitwise inverse
            sine_lookup = (idx <= 8'd128) ? signed'({1'b0, mag}) : signed'(~{1'b0, mag});
        end
    endfunction

endpackage

// ===== hdl/ttb_texel_store.sv =====
// ttb_texel_store: texel byte memory, one write port and two registered read ports
// depends on ttb_pkg for depth, address and control types

module ttb_texel_store
    import ttb_pkg::*;
(
    input  logic        i_clk,
    input  t_store_ctrl i_ctrl,
    input  t_tex_addr   i_wr_addr,
    input  t_texel      i_wr_data,
    input  t_tex_addr   i_rd_addr1,
    input  t_tex_addr   i_rd_addr2,
    output t_texel      o_rd_data1,
    output t_texel      o_rd_data2
);

    t_texel r_mem [TEXTURE_DEPTH];
    t_texel r_rd_data1;
    t_texel r_rd_data2;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while the pipeline is stalled
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_data1 <= r_mem[i_rd_addr1];
            r_rd_data2 <= r_mem[i_rd_addr2];
        end
    end

    assign o_rd_data1 = r_rd_data1;
    assign o_rd_data2 = r_rd_data2;

endmodule

// ===== hdl/twirl_texture_blender.sv =====
// Two-layer tunnel texture blender: one transaction per clock, four pipeline stages
// from input acceptance to the result register; pipeline throughput is set by the
// dual-read texel store, which serves both layer lookups of a draw in a single access.
// A stall at the output holds every stage. Writes store one texel and give no result;
// a draw sees every write accepted before it. Never-written texels read as garbage.
// Depends on ttb_pkg and ttb_texel_store.

module twirl_texture_blender
    import ttb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item input
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_command,
    input  logic [TADDR_W-1:0]  i_texel_address,
    input  logic [TEXEL_W-1:0]  i_texel_value,
    input  logic [MAP_W-1:0]    i_map_entry,
    // result output
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [TEXEL_W-1:0]  o_pixel_value,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    logic [FRAME_W-1:0] r_frame_count;
    logic               en;

    // stage 1: inputs and sine lookups
    logic               r_s1_valid;
    logic               r_s1_cmd;
    logic [TADDR_W-1:0] r_s1_waddr;
    t_texel             r_s1_wval;
    logic [MAP_W-1:0]   r_s1_map;
    logic [6:0]         r_s1_fc7;
    logic signed [7:0]  r_s1_v1;
    logic signed [7:0]  r_s1_u1;
    logic signed [7:0]  r_s1_u2;

    // stage 2: store addresses
    logic               r_s2_valid;
    logic               r_s2_cmd;
    logic [TADDR_W-1:0] r_s2_waddr;
    t_texel             r_s2_wval;
    t_tex_addr          r_s2_addr1;
    t_tex_addr          r_s2_addr2;

    // stage 3: store access
    logic               r_s3_valid;
    logic               r_s3_cmd;

    // stage 4: result register
    logic               r_s4_valid;
    t_texel             r_s4_pixel;

    logic [9:0]         n_c;
    logic [7:0]         n_idx_u1;
    logic [15:0]        n_ofs1;
    logic [15:0]        n_ofs2;
    logic [TADDR_W-1:0] n_addr1;
    logic [TADDR_W-1:0] n_addr2;
    logic [TEXEL_W:0]   n_sum;
    t_store_ctrl        store_ctrl;
    t_texel             rd_data1;
    t_texel             rd_data2;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FRAME_COUNT) ? APB_DW'(r_frame_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_COUNT) begin
            r_frame_count <= pwdata[FRAME_W-1:0];
        end
    end

    assign en         = !r_s4_valid || i_out_ready;
    assign o_in_ready = en;

    // only the low 10 bits of the frame count matter
    assign n_c      = r_frame_count[9:0];
    assign n_idx_u1 = 8'({1'b0, n_c[9:1]} + {2'b00, n_c[9:2]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid && (r_s3_cmd == CMD_DRAW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_cmd   <= i_command;
            r_s1_waddr <= i_texel_address;
            r_s1_wval  <= i_texel_value;
            r_s1_map   <= i_map_entry;
            r_s1_fc7   <= n_c[6:0];
            r_s1_v1    <= sine_lookup(n_c[7:0]);
            r_s1_u1    <= sine_lookup(n_idx_u1);
            r_s1_u2    <= sine_lookup(n_c[8:1]);
        end
    end

    // offsets wrap at 16 bits; u terms are sign extended
    assign n_ofs1  = {r_s1_v1, 8'h00} + {{8{r_s1_u1[7]}}, r_s1_u1};
    assign n_ofs2  = {r_s1_fc7, 9'h000} + {{8{r_s1_u2[7]}}, r_s1_u2};
    assign n_addr1 = {1'b0, r_s1_map} + {1'b0, n_ofs1};
    assign n_addr2 = {1'b0, r_s1_map} + {1'b0, n_ofs2};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_cmd   <= r_s1_cmd;
            r_s2_waddr <= r_s1_waddr;
            r_s2_wval  <= r_s1_wval;
            r_s2_addr1 <= TEX_AW'(n_addr1);
            r_s2_addr2 <= TEX_AW'(n_addr2);
        end
    end

    assign store_ctrl.wr_en = en && r_s2_valid && (r_s2_cmd == CMD_WRITE);
    assign store_ctrl.rd_en = en && r_s2_valid && (r_s2_cmd == CMD_DRAW);

    ttb_texel_store u_store (
        .i_clk      (i_clk),
        .i_ctrl     (store_ctrl),
        .i_wr_addr  (TEX_AW'(r_s2_waddr)),
        .i_wr_data  (r_s2_wval),
        .i_rd_addr1 (r_s2_addr1),
        .i_rd_addr2 (r_s2_addr2),
        .o_rd_data1 (rd_data1),
        .o_rd_data2 (rd_data2)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_cmd <= r_s2_cmd;
        end
    end

    assign n_sum = {1'b0, rd_data1} + {1'b0, rd_data2};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_pixel <= n_sum[TEXEL_W:1];
        end
    end

    assign o_out_valid   = r_s4_valid;
    assign o_pixel_value = r_s4_pixel;

endmodule

// ===== hdl/ttb_checker.sv =====
// ttb_checker: port-level assertions for twirl_texture_blender, attached by bind
// depends on ttb_pkg and the top level's port list

module ttb_checker
    import ttb_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [TEXEL_W-1:0] o_pixel_value,
    input logic               pready
);

    // a waiting result transaction is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a waiting result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_pixel_value))
        else $error("result changed while stalled");

    // input is taken unless a result is stuck at the output
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind twirl_texture_blender ttb_checker u_ttb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pixel_value (o_pixel_value),
    .pready        (pready)
);

// ===== dv/tb_twirl_texture_blender.sv =====
// tb_twirl_texture_blender: self-checking bench for the two-layer tunnel texel blender
// drives texel writes and pixel draws over valid/ready, sets frame_count over APB,
// and checks every pixel against an in-bench model; depends on ttb_pkg and the block RTL

module tb_twirl_texture_blender
    import ttb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int LIMIT_NS        = 5_000_000;

    // register index that no register decodes to
    localparam logic REG_UNMAPPED = ~REG_FRAME_COUNT;
    localparam logic [APB_AW-1:0] FRAME_ADDR    = {REG_FRAME_COUNT, 2'b00};
    localparam logic [APB_AW-1:0] UNMAPPED_ADDR = {REG_UNMAPPED, 2'b00};

    // texel store mirror, layer offsets and the pixels still owed by the block
    class pixel_scoreboard;
        bit [TEXEL_W-1:0]   texels [TEXTURE_DEPTH];
        logic [FRAME_W-1:0] frame;
        logic [TEXEL_W-1:0] pixels_due [$];
        int                 qwave [65];
        int                 mismatches;
        int                 writes_seen;
        int                 draws_seen;
        int                 pixels_checked;

        function new();
            qwave = '{0, 3, 6, 9, 12, 15, 18, 21, 24, 28, 31, 34, 37, 40, 43, 46,
                      48, 51, 54, 57, 60, 63, 65, 68, 71, 73, 76, 78, 81, 83, 85, 88,
                      90, 92, 94, 96, 98, 100, 102, 104, 106, 108, 109, 111, 112, 114,
                      115, 117, 118, 119, 120, 121, 122, 123, 124, 124, 125, 126, 126,
                      127, 127, 127, 127, 127, 127};
            frame = '0;
        endfunction

        // sin scaled to 32767, truncated, then arithmetic shift by 8
        function int shifted_sine(input int idx);
            int m;
            int q;
            m = (idx <= 128) ? idx : idx - 128;
            q = (m <= 64) ? m : 128 - m;
            return (idx <= 128) ? qwave[q] : -(qwave[q] + 1);
        endfunction

        function void layer_targets(input logic [MAP_W-1:0] map,
                                    output int unsigned a1, output int unsigned a2);
            int c;
            int ofs1;
            int ofs2;
            c    = int'(frame) & 'h3FF;
            ofs1 = ((shifted_sine(c & 255) <<< 8)
                    + shifted_sine(((c >> 1) + (c >> 2)) & 255)) & 'hFFFF;
            ofs2 = ((c << 9) + shifted_sine((c >> 1) & 255)) & 'hFFFF;
            a1   = (int'(map) + ofs1) % TEXTURE_DEPTH;
            a2   = (int'(map) + ofs2) % TEXTURE_DEPTH;
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction

        task report(input string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        function void note_item(input logic cmd, input logic [TADDR_W-1:0] addr,
                                input logic [TEXEL_W-1:0] value, input logic [MAP_W-1:0] map);
            int unsigned a1;
            int unsigned a2;
            int          sum;
            if (cmd == CMD_WRITE) begin
                texels[addr % TEXTURE_DEPTH] = value;
                writes_seen++;
            end else begin
                layer_targets(map, a1, a2);
                sum = int'(texels[a1]) + int'(texels[a2]);
                pixels_due.push_back(TEXEL_W'(sum >> 1));
                draws_seen++;
            end
        endfunction

        task check_pixel(input logic [TEXEL_W-1:0] pixel);
            logic [TEXEL_W-1:0] want;
            if (pixels_due.size() == 0) begin
                report($sformatf("pixel %0d with no draw outstanding", pixel));
            end else begin
                want = pixels_due.pop_front();
                pixels_checked++;
                if (pixel !== want)
                    report($sformatf("pixel_value %0d, predicted %0d", pixel, want));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_command;
    logic [TADDR_W-1:0] i_texel_address;
    logic [TEXEL_W-1:0] i_texel_value;
    logic [MAP_W-1:0]   i_map_entry;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [TEXEL_W-1:0] o_pixel_value;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    pixel_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int items_sent;
    bit stocked [TEXTURE_DEPTH];

    twirl_texture_blender DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_texel_address (i_texel_address),
        .i_texel_value   (i_texel_value),
        .i_map_entry     (i_map_entry),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_value   (o_pixel_value),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("timeout: %0d items sent, %0d pixels outstanding", items_sent, sb.pending());
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random stalls plus an occasional long hold-off
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // check results before noting new transactions on the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_pixel(o_pixel_value);
            if (i_in_valid && o_in_ready)
                sb.note_item(i_command, i_texel_address, i_texel_value, i_map_entry);
        end
    end

    // all driving tasks start and end at a falling edge
    task automatic send_item(input logic cmd, input logic [TADDR_W-1:0] addr,
                             input logic [TEXEL_W-1:0] value, input logic [MAP_W-1:0] map);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_texel_address <= addr;
        i_texel_value   <= value;
        i_map_entry     <= map;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic stock_texel(input int unsigned addr, input logic [TEXEL_W-1:0] value);
        send_item(CMD_WRITE, TADDR_W'(addr), value, MAP_W'($urandom_range(0, 16'hFFFF)));
        stocked[addr] = 1'b1;
    endtask

    task automatic draw_pixel(input logic [MAP_W-1:0] map);
        send_item(CMD_DRAW, TADDR_W'($urandom_range(0, TEXTURE_DEPTH - 1)),
                  TEXEL_W'($urandom_range(0, 255)), map);
    endtask

    // make sure both layer texels hold data, sometimes refresh them, then draw
    task automatic draw_sequence(input logic [MAP_W-1:0] map);
        int unsigned a1;
        int unsigned a2;
        sb.layer_targets(map, a1, a2);
        if (!stocked[a1] || $urandom_range(0, 3) == 0)
            stock_texel(a1, TEXEL_W'($urandom_range(0, 255)));
        if (!stocked[a2] || $urandom_range(0, 3) == 0)
            stock_texel(a2, TEXEL_W'($urandom_range(0, 255)));
        draw_pixel(map);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_frame_readback();
        logic [APB_DW-1:0] rd;
        apb_read(FRAME_ADDR, rd);
        if (rd[FRAME_W-1:0] !== sb.frame)
            sb.report($sformatf("frame_count read %0h, written %0h", rd[FRAME_W-1:0], sb.frame));
    endtask

    task automatic program_frame(input logic [FRAME_W-1:0] frame);
        apb_write(FRAME_ADDR, {{(APB_DW-FRAME_W){1'b0}}, frame});
        sb.frame = frame;
        check_frame_readback();
    endtask

    // trailing writes give no pixel, so also let a few output-ready cycles pass
    task automatic wait_idle(input int limit);
        int ready_cycles;
        int waited;
        ready_cycles = 0;
        waited       = 0;
        i_in_valid <= 1'b0;
        while ((sb.pending() != 0 || hold_left > 0 || ready_cycles < 10) && waited < limit) begin
            @(posedge i_clk);
            waited++;
            if (sb.pending() == 0 && hold_left == 0 && i_out_ready)
                ready_cycles++;
        end
        @(negedge i_clk);
    endtask

    initial begin
        logic [FRAME_W-1:0] frame_plan [PHASES];
        logic [MAP_W-1:0]   map_pool [$];
        logic [MAP_W-1:0]   map;
        int unsigned        a1;
        int unsigned        a2;
        int                 phase_start;
        bit                 held;

        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_command       = CMD_WRITE;
        i_texel_address = '0;
        i_texel_value   = '0;
        i_map_entry     = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_left       = 0;
        items_sent      = 0;

        // 0x400 aliases 0 in the low ten bits; 0x80/0x81 straddle the sine sign change
        frame_plan = '{16'h0000, 16'hFFFF, 16'h03FF, 16'h0400, 16'h0080, 16'h0081,
                       FRAME_W'($urandom_range(0, 16'hFFFF)),
                       FRAME_W'($urandom_range(0, 16'hFFFF))};

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 28;
                recv_idle_pct = 56;
            end else if (ph < 6) begin
                send_idle_pct = 56;
                recv_idle_pct = 28;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph > 0)
                wait_idle(DRAIN_LIMIT);
            program_frame(frame_plan[ph]);

            if (ph == 0) begin
                // both layers land on the map address itself at frame zero
                stock_texel(0, 8'hFF);
                draw_pixel(16'h0000);
                stock_texel(16'hFFFF, 8'h00);
                draw_pixel(16'hFFFF);
                stock_texel(TEXTURE_DEPTH - 1, 8'hA5);
                // draw right behind the write it depends on
                stock_texel(0, 8'h01);
                draw_pixel(16'h0000);
            end else if (ph == 1) begin
                // odd sum is truncated; all-ones texels stay in range
                sb.layer_targets(16'h0000, a1, a2);
                stock_texel(a1, 8'hFF);
                stock_texel(a2, 8'hFE);
                draw_pixel(16'h0000);
                sb.layer_targets(16'hFFFF, a1, a2);
                stock_texel(a1, 8'hFF);
                stock_texel(a2, 8'hFF);
                draw_pixel(16'hFFFF);
                stock_texel(a2, 8'h00);
                draw_pixel(16'hFFFF);
                // a write to an unmapped register must leave frame_count alone
                wait_idle(DRAIN_LIMIT);
                apb_write(UNMAPPED_ADDR, '1);
                check_frame_readback();
                draw_pixel(16'h0000);
                draw_pixel(16'hFFFF);
            end

            phase_start = items_sent;
            held        = 1'b0;
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                if ((ph == 2 || ph == 6) && !held
                    && items_sent - phase_start >= ITEMS_PER_PHASE / 2) begin
                    hold_left = HOLD_CYCLES;
                    held      = 1'b1;
                end
                if ($urandom_range(0, 99) < 60) begin
                    if (map_pool.size() > 0 && $urandom_range(0, 2) == 0)
                        map = map_pool[$urandom_range(0, map_pool.size() - 1)];
                    else
                        map = MAP_W'($urandom_range(0, 16'hFFFF));
                    map_pool.push_back(map);
                    if (map_pool.size() > 64)
                        void'(map_pool.pop_front());
                    draw_sequence(map);
                end else begin
                    stock_texel($urandom_range(0, TEXTURE_DEPTH - 1),
                                TEXEL_W'($urandom_range(0, 255)));
                end
            end
        end

        wait_idle(DRAIN_LIMIT);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d predicted pixels never arrived", sb.pending()));

        $display("covered %0d texel writes and %0d draws over %0d frame_count settings",
                 sb.writes_seen, sb.draws_seen, PHASES);
        $display("%0d pixels checked, %0d mismatches", sb.pixels_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== twirl_texture_blender.f =====
hdl/ttb_pkg.sv
hdl/ttb_texel_store.sv
hdl/twirl_texture_blender.sv
hdl/ttb_checker.sv
dv/tb_twirl_texture_blender.sv
